>>> rtl/core/lsnm_pkg.sv
// Shared types and constants for the line segment nearest match core.
`default_nettype none

package lsnm_pkg;

   // Item operation codes
   localparam logic [1:0] OP_CLEAR = 2'd0;
   localparam logic [1:0] OP_LOAD  = 2'd1;
   localparam logic [1:0] OP_QUERY = 2'd2;

   // Configuration register indexes
   localparam logic [1:0] CSR_ANGLE_COS  = 2'd0;
   localparam logic [1:0] CSR_DIST_LIMIT = 2'd1;
   localparam logic [1:0] CSR_OVERLAP    = 2'd2;

   // Configuration reset values
   localparam logic [14:0] ANGLE_COS_RESET  = 15'd16322;
   localparam logic [14:0] DIST_LIMIT_RESET = 15'd800;
   localparam logic [14:0] OVERLAP_RESET    = 15'd160;

   localparam int FRAC_BITS = 14;

   typedef struct packed {
      logic [1:0]         opcode;
      logic signed [15:0] center_x;
      logic signed [15:0] center_y;
      logic signed [15:0] dir_x;
      logic signed [15:0] dir_y;
      logic [14:0]        half_length;
   } req_type;

   typedef struct packed {
      logic               found;
      logic [7:0]         match_index;
      logic signed [15:0] perpendicular_offset;
   } rsp_type;

   // One stored reference segment
   typedef struct packed {
      logic signed [15:0] cx;
      logic signed [15:0] cy;
      logic signed [15:0] vx;
      logic signed [15:0] vy;
      logic [14:0]        hl;
   } entry_type;

endpackage

`default_nettype wire

>>> rtl/core/line_segment_nearest_match_core.sv
// Line segment nearest match core: segment table memory and scan pipeline.
// Clear, load and unused opcodes leave the core idle; the next item is accepted
// on the following cycle. A query over N >= 1 stored segments reads the table
// one entry per cycle, drains a memory stage plus a five stage compare
// pipeline and then loads the result register; the next item is accepted
// only after the core returns to idle. A held result keeps a finished query
// in its reply state until rsp_stall drops.
// Reset (synchronous, active high) empties the table and restores the
// configuration defaults; the table memory itself is not cleared.
`default_nettype none

module line_segment_nearest_match_core
   import lsnm_pkg::*;
#(
   parameter int MAX_LINES = 256
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire req_type     req_data,
   // response channel
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output rsp_type          rsp_data,
   // configuration write channel
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [14:0] csr_wdata
);

   localparam int AW = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
   localparam int CW = AW + 1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_REPLY
   } state_type;

   // ---------------------------------------------------------------------
   // Configuration registers. Writes must only arrive while the core is idle;
   // the block itself does not enforce this. The port is always ready.
   // ---------------------------------------------------------------------
   logic [14:0] angle_cos_ff;
   logic [14:0] dist_limit_ff;
   logic [14:0] overlap_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         angle_cos_ff  <= ANGLE_COS_RESET;
         dist_limit_ff <= DIST_LIMIT_RESET;
         overlap_ff    <= OVERLAP_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_ANGLE_COS:  angle_cos_ff  <= csr_wdata;
            CSR_DIST_LIMIT: dist_limit_ff <= csr_wdata;
            CSR_OVERLAP:    overlap_ff    <= csr_wdata;
            default:        ;
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Control: state, table fill count, scan index, query operands and the
   // response register.
   // ---------------------------------------------------------------------
   state_type          state_ff;
   logic [CW-1:0]      count_ff;
   logic [CW-1:0]      idx_ff;
   logic signed [15:0] q_cx_ff, q_cy_ff, q_ux_ff, q_uy_ff;
   logic [14:0]        q_hl_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_data_ff;

   logic               req_take;
   logic               mem_we;
   logic               rd_en;
   logic               rsp_free;
   logic               pipe_busy;
   logic               query_start;

   // best-match tracker, updated by the last pipeline stage
   logic               best_found_ff;
   logic [AW-1:0]      best_idx_ff;
   logic signed [34:0] best_t_ff;
   logic [34:0]        best_abs_ff;

   logic [AW+7:0]      best_idx_ext;
   logic signed [35:0] round_sum;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign mem_we    = req_take && (req_data.opcode == OP_LOAD)
                      && (count_ff < CW'(MAX_LINES));
   assign query_start = req_take && (req_data.opcode == OP_QUERY);
   assign rd_en     = (state_ff == ST_SCAN) && (idx_ff != count_ff);
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   // offset rounded to nearest, ties upward
   assign best_idx_ext = {8'd0, best_idx_ff};
   assign round_sum    = 36'(best_t_ff) + 36'sd8192;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if ((state_ff == ST_REPLY) && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_take) begin
                  case (req_data.opcode)
                     OP_CLEAR: count_ff <= '0;
                     OP_LOAD: begin
                        if (mem_we) begin
                           count_ff <= count_ff + CW'(1);
                        end
                     end
                     OP_QUERY: begin
                        idx_ff   <= '0;
                        state_ff <= ST_SCAN;
                     end
                     default: ;
                  endcase
               end
            end
            ST_SCAN: begin
               if (rd_en) begin
                  idx_ff <= idx_ff + CW'(1);
               end else begin
                  state_ff <= ST_DRAIN;
               end
            end
            ST_DRAIN: begin
               if (!pipe_busy) begin
                  state_ff <= ST_REPLY;
               end
            end
            ST_REPLY: begin
               // result waits here until the output register is free
               if (rsp_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // query operands and response payload
   always_ff @(posedge clock) begin
      if (query_start) begin
         q_cx_ff <= req_data.center_x;
         q_cy_ff <= req_data.center_y;
         q_ux_ff <= req_data.dir_x;
         q_uy_ff <= req_data.dir_y;
         q_hl_ff <= req_data.half_length;
      end
      if ((state_ff == ST_REPLY) && rsp_free) begin
         rsp_data_ff.found <= best_found_ff;
         rsp_data_ff.match_index <= best_found_ff ? best_idx_ext[7:0] : 8'd0;
         rsp_data_ff.perpendicular_offset <=
            best_found_ff ? round_sum[FRAC_BITS+15:FRAC_BITS] : 16'sd0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ---------------------------------------------------------------------
   // Segment table: one synchronous memory, written by loads, read once
   // per cycle during a scan. Loads and scans never overlap.
   // ---------------------------------------------------------------------
   entry_type mem [MAX_LINES];
   entry_type mem_q_ff;
   entry_type wr_entry;

   assign wr_entry = '{cx: req_data.center_x, cy: req_data.center_y,
                       vx: req_data.dir_x, vy: req_data.dir_y,
                       hl: req_data.half_length};

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[count_ff[AW-1:0]] <= wr_entry;
      end
      if (rd_en) begin
         mem_q_ff <= mem[idx_ff[AW-1:0]];
      end
   end

   // ---------------------------------------------------------------------
   // Compare pipeline
   //   P0: memory data   A: differences   B: products
   //   C: dot products   D: tests         E: best update
   // ---------------------------------------------------------------------
   logic          p0_valid_ff, a_valid_ff, b_valid_ff, c_valid_ff, d_valid_ff;
   logic [AW-1:0] p0_idx_ff, a_idx_ff, b_idx_ff, c_idx_ff, d_idx_ff;

   assign pipe_busy = p0_valid_ff || a_valid_ff || b_valid_ff
                      || c_valid_ff || d_valid_ff;

   // stage A
   logic signed [16:0] a_dx_in, a_dy_in, a_lim1_in;
   logic signed [16:0] a_dx_ff, a_dy_ff, a_lim1_ff;
   logic signed [15:0] a_vx_ff, a_vy_ff;

   assign a_dx_in   = 17'(mem_q_ff.cx) - 17'(q_cx_ff);
   assign a_dy_in   = 17'(mem_q_ff.cy) - 17'(q_cy_ff);
   assign a_lim1_in = $signed({2'b00, mem_q_ff.hl}) - $signed({2'b00, overlap_ff});

   // stage B
   logic signed [31:0] b_cos0_ff, b_cos1_ff;
   logic signed [32:0] b_t00_ff, b_t01_ff, b_t10_ff, b_t11_ff, b_n0_ff, b_n1_ff;
   logic signed [16:0] b_lim1_ff;

   // stage C
   logic signed [34:0] c_cos_in, c_t0_in, c_t1_in, c_t_in;
   logic signed [34:0] c_cos_ff, c_t0_ff, c_t1_ff, c_t_ff;
   logic signed [16:0] c_lim1_ff;

   assign c_cos_in = 35'(b_cos0_ff) + 35'(b_cos1_ff);
   assign c_t0_in  = 35'(b_t00_ff) + 35'(b_t01_ff);
   assign c_t1_in  = -(35'(b_t10_ff) + 35'(b_t11_ff));
   assign c_t_in   = 35'(b_n0_ff) - 35'(b_n1_ff);

   // stage D: angle, overlap and distance tests
   logic signed [16:0] lim0;
   logic signed [34:0] span0, span1;
   logic [34:0]        abs_cos, abs_t;
   logic               angle_ok, out0, out1, dist_ok, d_pass_in;
   logic               d_pass_ff;
   logic signed [34:0] d_t_ff;
   logic [34:0]        d_abs_ff;

   assign lim0  = $signed({2'b00, q_hl_ff}) - $signed({2'b00, overlap_ff});
   assign span0 = 35'($signed({lim0, 14'd0}));
   assign span1 = 35'($signed({c_lim1_ff, 14'd0}));
   assign abs_cos = c_cos_ff[34] ? 35'(-c_cos_ff) : 35'(c_cos_ff);
   assign abs_t   = c_t_ff[34] ? 35'(-c_t_ff) : 35'(c_t_ff);
   assign angle_ok = abs_cos >= {6'd0, angle_cos_ff, 14'd0};
   // empty shrunk span (negative limit) always counts as outside
   assign out0 = (c_t0_ff < -span0) || (c_t0_ff > span0);
   assign out1 = (c_t1_ff < -span1) || (c_t1_ff > span1);
   assign dist_ok  = abs_t <= {6'd0, dist_limit_ff, 14'd0};
   assign d_pass_in = angle_ok && !(out0 && out1) && dist_ok;

   always_ff @(posedge clock) begin
      if (reset) begin
         p0_valid_ff <= 1'b0;
         a_valid_ff  <= 1'b0;
         b_valid_ff  <= 1'b0;
         c_valid_ff  <= 1'b0;
         d_valid_ff  <= 1'b0;
      end else begin
         p0_valid_ff <= rd_en;
         a_valid_ff  <= p0_valid_ff;
         b_valid_ff  <= a_valid_ff;
         c_valid_ff  <= b_valid_ff;
         d_valid_ff  <= c_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      p0_idx_ff <= idx_ff[AW-1:0];
      // A
      a_idx_ff  <= p0_idx_ff;
      a_dx_ff   <= a_dx_in;
      a_dy_ff   <= a_dy_in;
      a_lim1_ff <= a_lim1_in;
      a_vx_ff   <= mem_q_ff.vx;
      a_vy_ff   <= mem_q_ff.vy;
      // B
      b_idx_ff  <= a_idx_ff;
      b_lim1_ff <= a_lim1_ff;
      b_cos0_ff <= q_ux_ff * a_vx_ff;
      b_cos1_ff <= q_uy_ff * a_vy_ff;
      b_t00_ff  <= q_ux_ff * a_dx_ff;
      b_t01_ff  <= q_uy_ff * a_dy_ff;
      b_t10_ff  <= a_vx_ff * a_dx_ff;
      b_t11_ff  <= a_vy_ff * a_dy_ff;
      b_n0_ff   <= q_uy_ff * a_dx_ff;
      b_n1_ff   <= q_ux_ff * a_dy_ff;
      // C
      c_idx_ff  <= b_idx_ff;
      c_lim1_ff <= b_lim1_ff;
      c_cos_ff  <= c_cos_in;
      c_t0_ff   <= c_t0_in;
      c_t1_ff   <= c_t1_in;
      c_t_ff    <= c_t_in;
      // D
      d_idx_ff  <= c_idx_ff;
      d_pass_ff <= d_pass_in;
      d_t_ff    <= c_t_ff;
      d_abs_ff  <= abs_t;
   end

   // stage E: strict less-than keeps the first index on ties
   always_ff @(posedge clock) begin
      if (reset) begin
         best_found_ff <= 1'b0;
      end else if (query_start) begin
         best_found_ff <= 1'b0;
      end else if (d_valid_ff && d_pass_ff
                   && (!best_found_ff || (d_abs_ff < best_abs_ff))) begin
         best_found_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (d_valid_ff && d_pass_ff && (!best_found_ff || (d_abs_ff < best_abs_ff))) begin
         best_idx_ff <= d_idx_ff;
         best_t_ff   <= d_t_ff;
         best_abs_ff <= d_abs_ff;
      end
   end

endmodule

`default_nettype wire

>>> test/testbench.sv
// Self-checking testbench for the line segment nearest match core.
`default_nettype none

module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import lsnm_pkg::*;

   localparam int          MAX_LINES   = 256;
   localparam int          ITEM_TARGET = 1150;
   localparam int          PHASE_ITEMS = 140;
   localparam int          HOLD_CYCLES = 3000;
   // a full-table query scans 256 entries plus the compare pipeline
   localparam int          END_WAIT    = 300;
   localparam int          CYCLE_LIMIT = 2000000;
   // index 3 is not a register; writes there must be ignored
   localparam logic [1:0]  CSR_SPARE   = 2'd3;
   // opcode 3 is unused; such items change nothing
   localparam logic [1:0]  OP_SPARE    = 2'd3;

   // Predicts the match answer of every query from a private copy of the
   // segment store and the thresholds, and holds the answers still owed.
   class match_scoreboard #(int DEPTH = 256);
      entry_type   seg_store [DEPTH];
      int unsigned line_count;
      logic [14:0] cos_min;
      logic [14:0] dist_max;
      logic [14:0] margin;
      rsp_type     answer_q [$];
      int unsigned error_count;

      function new();
         line_count  = 0;
         cos_min     = ANGLE_COS_RESET;
         dist_max    = DIST_LIMIT_RESET;
         margin      = OVERLAP_RESET;
         error_count = 0;
      endfunction

      function void write_reg(logic [1:0] idx, logic [14:0] val);
         case (idx)
            CSR_ANGLE_COS:  cos_min  = val;
            CSR_DIST_LIMIT: dist_max = val;
            CSR_OVERLAP:    margin   = val;
            default: ;
         endcase
      endfunction

      function longint mag(longint v);
         return (v < 0) ? -v : v;
      endfunction

      // projection t (scaled 2^14) outside the span shrunk by the margin
      function bit off_span(longint t, longint h);
         longint lim;
         lim = (h - longint'(margin)) * 16384;
         return (t < -lim) || (t > lim);
      endfunction

      function void note_item(req_type r);
         entry_type e;
         longint    bx, by, ux, uy, bh, vx, vy, vh;
         longint    cosv, dx, dy, t0, t1, t, best_t, rounded;
         int        best;
         bit        hit;
         rsp_type   ans;
         case (r.opcode)
            OP_CLEAR: line_count = 0;
            OP_LOAD: begin
               if (line_count < DEPTH) begin
                  seg_store[line_count] = '{r.center_x, r.center_y, r.dir_x, r.dir_y,
                                            r.half_length};
                  line_count++;
               end
            end
            OP_QUERY: begin
               bx = longint'($signed(r.center_x));
               by = longint'($signed(r.center_y));
               ux = longint'($signed(r.dir_x));
               uy = longint'($signed(r.dir_y));
               bh = longint'(r.half_length);
               hit = 1'b0;
               best = 0;
               best_t = 0;
               for (int i = 0; i < int'(line_count); i++) begin
                  e  = seg_store[i];
                  vx = longint'($signed(e.vx));
                  vy = longint'($signed(e.vy));
                  vh = longint'(e.hl);
                  cosv = ux * vx + uy * vy;
                  if (mag(cosv) < longint'(cos_min) * 16384) continue;
                  dx = longint'($signed(e.cx)) - bx;
                  dy = longint'($signed(e.cy)) - by;
                  t0 = ux * dx + uy * dy;
                  t1 = -(vx * dx + vy * dy);
                  if (off_span(t0, bh) && off_span(t1, vh)) continue;
                  t = uy * dx - ux * dy;
                  if (mag(t) > longint'(dist_max) * 16384) continue;
                  if (!hit || mag(t) < mag(best_t)) begin
                     hit = 1'b1;
                     best = i;
                     best_t = t;
                  end
               end
               // round to nearest, ties toward plus infinity
               rounded = (best_t + 8192) >>> 14;
               ans.found = hit;
               ans.match_index = hit ? best[7:0] : 8'd0;
               ans.perpendicular_offset = hit ? rounded[15:0] : 16'sd0;
               answer_q.push_back(ans);
            end
            default: ;
         endcase
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (answer_q.size() == 0) begin
            $error("unexpected result: found %0d index %0d offset %0d",
                   got.found, got.match_index, got.perpendicular_offset);
            error_count++;
            return;
         end
         want = answer_q.pop_front();
         if (got.found !== want.found) begin
            $error("found: expected %0d, actual %0d", want.found, got.found);
            error_count++;
         end
         if (got.match_index !== want.match_index) begin
            $error("match_index: expected %0d, actual %0d", want.match_index, got.match_index);
            error_count++;
         end
         if (got.perpendicular_offset !== want.perpendicular_offset) begin
            $error("perpendicular_offset: expected %0d, actual %0d",
                   want.perpendicular_offset, got.perpendicular_offset);
            error_count++;
         end
      endfunction

      function int pending();
         return answer_q.size();
      endfunction
   endclass

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_data  = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [14:0] csr_wdata = '0;

   match_scoreboard #(MAX_LINES) sb;

   int unsigned cycle_count = 0;
   int          sent_count  = 0;
   int          burst_left  = 1;
   bit          valid_up    = 1'b0;   // mirrors the last value given to req_valid
   bit          hold_go     = 1'b0;   // asks the receiver for one long hold-off

   line_segment_nearest_match_core #(.MAX_LINES(MAX_LINES)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Result monitor: values read here are those present at the edge.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_result(rsp_data);
   end

   // Receiver stall pattern: stretches of no stall, light and heavy random
   // stalling, and one long hold-off on request so the core backs up.
   initial begin
      int mode;
      int phase_left;
      int hold_left;
      mode = 0;
      phase_left = 0;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (hold_go) begin
            hold_go = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            if (phase_left == 0) begin
               mode = $urandom_range(0, 2);
               phase_left = $urandom_range(20, 300);
            end
            phase_left--;
            case (mode)
               0:       rsp_stall <= 1'b0;
               1:       rsp_stall <= ($urandom_range(0, 3) == 0);
               default: rsp_stall <= ($urandom_range(0, 3) != 0);
            endcase
         end
      end
   end

   function automatic int rnd_sym(int lim);
      return int'($urandom_range(0, 2 * lim)) - lim;
   endfunction

   function automatic logic signed [15:0] clip16(real v);
      if (v > 32767.0) return 16'sd32767;
      if (v < -32768.0) return -16'sd32768;
      return 16'($rtoi(v));
   endfunction

   function automatic req_type seg(logic [1:0] op, int cx, int cy, int ux, int uy, int h);
      req_type r;
      r.opcode      = op;
      r.center_x    = 16'(cx);
      r.center_y    = 16'(cy);
      r.dir_x       = 16'(ux);
      r.dir_y       = 16'(uy);
      r.half_length = 15'(h);
      return r;
   endfunction

   // Fully random item, any opcode, any bit pattern in every field.
   function automatic req_type noise_item();
      req_type r;
      r.opcode      = 2'($urandom_range(0, 3));
      r.center_x    = 16'($urandom);
      r.center_y    = 16'($urandom);
      r.dir_x       = 16'($urandom);
      r.dir_y       = 16'($urandom);
      r.half_length = 15'($urandom);
      return r;
   endfunction

   // Segment close to a base line: small angle error, sometimes reversed,
   // shifted along the line and off to the side.
   function automatic req_type near_seg(logic [1:0] op, real bx, real by, real ba, int bh);
      req_type r;
      real     a;
      real     along;
      real     off;
      int      h;
      a = ba + real'(rnd_sym(1000)) / 10000.0;
      if ($urandom_range(0, 3) == 0) a = a + 3.14159265;
      along = real'(rnd_sym(bh + bh / 4));
      off = ($urandom_range(0, 7) == 0) ? 0.0 : real'(rnd_sym(1500));
      h = bh + rnd_sym(bh / 2);
      r.opcode      = op;
      r.center_x    = clip16(bx + along * $cos(ba) - off * $sin(ba));
      r.center_y    = clip16(by + along * $sin(ba) + off * $cos(ba));
      r.dir_x       = 16'($rtoi($floor(16384.0 * $cos(a) + 0.5)));
      r.dir_y       = 16'($rtoi($floor(16384.0 * $sin(a) + 0.5)));
      r.half_length = 15'(h);
      return r;
   endfunction

   // Offer one item and hold it until accepted; then maybe idle a while.
   task automatic push_item(req_type r);
      int gap;
      req_valid <= 1'b1;
      req_data  <= r;
      valid_up = 1'b1;
      do @(posedge clock); while (req_stall);
      sb.note_item(r);
      sent_count++;
      burst_left--;
      if (burst_left <= 0) begin
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 25);
         if (gap > 0) begin
            req_valid <= 1'b0;
            valid_up = 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
   endtask

   // Sender stops until every owed answer is in, then lets the core settle.
   task automatic drain_results();
      if (valid_up) begin
         req_valid <= 1'b0;
         valid_up = 1'b0;
      end
      while (sb.pending() != 0) @(posedge clock);
      repeat (END_WAIT) @(posedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [14:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(idx, val);
   endtask

   task automatic set_config(logic [14:0] cos_val, logic [14:0] dist_val,
                             logic [14:0] margin_val);
      drain_results();
      write_csr(CSR_ANGLE_COS, cos_val);
      write_csr(CSR_DIST_LIMIT, dist_val);
      write_csr(CSR_OVERLAP, margin_val);
      if ($urandom_range(0, 1) == 1) write_csr(CSR_SPARE, 15'($urandom));
      csr_valid <= 1'b0;
   endtask

   task automatic apply_phase(int p);
      case (p % 7)
         0: set_config(15'd0, 15'd32767, 15'd0);
         1: set_config(15'd16384, 15'd32767, 15'd0);
         2: set_config(ANGLE_COS_RESET, DIST_LIMIT_RESET, OVERLAP_RESET);
         3: set_config(15'($urandom_range(0, 16384)), 15'($urandom_range(0, 32767)),
                       15'($urandom_range(0, 32767)));
         4: set_config(15'd15000, 15'd0, 15'd32767);
         5: set_config(15'd16000, 15'd2000, 15'd500);
         default: set_config(15'($urandom_range(15000, 16384)), 15'($urandom_range(0, 3000)),
                             15'($urandom_range(0, 800)));
      endcase
   endtask

   // A base line, a handful of reference segments around it, then queries.
   task automatic run_scene();
      real bx;
      real by;
      real ba;
      int  bh;
      req_type r;
      bx = real'(rnd_sym(20000));
      by = real'(rnd_sym(20000));
      ba = real'($urandom_range(0, 62831)) / 10000.0;
      bh = $urandom_range(100, 4000);
      if ($urandom_range(0, 3) != 0) begin
         r = noise_item();
         r.opcode = OP_CLEAR;
         push_item(r);
      end
      repeat ($urandom_range(0, 12)) push_item(near_seg(OP_LOAD, bx, by, ba, bh));
      repeat ($urandom_range(1, 4)) push_item(near_seg(OP_QUERY, bx, by, ba, bh));
   endtask

   // Fill every entry, push a few loads into the full table, then query.
   task automatic fill_store();
      real bx;
      real by;
      real ba;
      bx = real'(rnd_sym(10000));
      by = real'(rnd_sym(10000));
      ba = real'($urandom_range(0, 62831)) / 10000.0;
      push_item(seg(OP_CLEAR, 0, 0, 0, 0, 0));
      repeat (MAX_LINES + 3) push_item(near_seg(OP_LOAD, bx, by, ba, 2000));
      repeat (3) push_item(near_seg(OP_QUERY, bx, by, ba, 2000));
   endtask

   initial begin
      int  phase;
      int  next_phase_at;
      bit  hold_done;
      bit  fill_done;
      sb = new();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // ---- directed part, reset thresholds ----
      // query on an empty table: answer with found clear
      push_item(seg(OP_QUERY, -32768, 32767, 16384, 0, 32767));
      // unused opcode: ignored, no answer
      push_item(seg(OP_SPARE, -1, -1, -1, -1, 32767));
      // two identical segments: a tie goes to the lower index
      push_item(seg(OP_LOAD, 0, 0, 16384, 0, 1600));
      push_item(seg(OP_LOAD, 0, 0, 16384, 0, 1600));
      push_item(seg(OP_QUERY, 0, 0, 16384, 0, 1600));
      // reversed direction still passes on absolute cosine
      push_item(seg(OP_QUERY, 0, 100, -16384, 0, 1600));
      // extreme corners, extreme half lengths
      push_item(seg(OP_LOAD, 32767, -32768, 0, -16384, 32767));
      push_item(seg(OP_LOAD, -32768, 32767, 0, 16384, 0));
      push_item(seg(OP_QUERY, 32767, -32768, 0, 16384, 0));
      push_item(seg(OP_QUERY, -32768, 32767, 0, -16384, 0));
      // margin wider than both half lengths: spans empty, no match
      push_item(seg(OP_CLEAR, 0, 0, 0, 0, 0));
      push_item(seg(OP_LOAD, 0, 0, 16384, 0, 100));
      push_item(seg(OP_QUERY, 0, 0, 16384, 0, 100));
      // offset one past the distance limit, then exactly on it
      push_item(seg(OP_CLEAR, 0, 0, 0, 0, 0));
      push_item(seg(OP_LOAD, 0, -801, 16384, 0, 1600));
      push_item(seg(OP_LOAD, 0, 800, 16384, 0, 1600));
      push_item(seg(OP_QUERY, 0, 0, 16384, 0, 1600));
      // direction not of unit length, zero direction
      push_item(seg(OP_LOAD, 5, 5, 0, 0, 1600));
      push_item(seg(OP_QUERY, 0, 0, 0, 0, 1600));
      // cleared table answers not found
      push_item(seg(OP_CLEAR, 0, 0, 0, 0, 0));
      push_item(seg(OP_QUERY, 0, 0, 16384, 0, 1600));

      // half-length query direction: cosine sits exactly on the threshold
      // and the offset lands on half a unit, rounding toward plus infinity
      set_config(15'd8192, DIST_LIMIT_RESET, OVERLAP_RESET);
      push_item(seg(OP_LOAD, 0, 1, 16384, 0, 1000));
      push_item(seg(OP_QUERY, 0, 0, 8192, 0, 1000));
      push_item(seg(OP_CLEAR, 0, 0, 0, 0, 0));
      push_item(seg(OP_LOAD, 0, -1, 16384, 0, 1000));
      push_item(seg(OP_QUERY, 0, 0, 8192, 0, 1000));

      // ---- random part ----
      phase = 0;
      next_phase_at = sent_count;
      hold_done = 1'b0;
      fill_done = 1'b0;
      while (sent_count < ITEM_TARGET) begin
         if (sent_count >= next_phase_at) begin
            apply_phase(phase);
            phase++;
            next_phase_at = sent_count + PHASE_ITEMS;
         end
         // long receiver hold-off while the sender keeps offering
         if (!hold_done && sent_count > 450) begin
            hold_go = 1'b1;
            hold_done = 1'b1;
         end
         if (!fill_done && sent_count > 600) begin
            fill_store();
            fill_done = 1'b1;
         end
         if ($urandom_range(0, 9) < 8) run_scene();
         else repeat ($urandom_range(1, 6)) push_item(noise_item());
      end

      drain_results();
      if (sb.pending() != 0) begin
         $error("%0d expected results never arrived", sb.pending());
         sb.error_count++;
      end
      if (sb.error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

`default_nettype wire
